FILE: sv/sbc_pkg.sv
// Shared types and constants for the stack byte code core.
// Used by sbc_alu and stack_bytecode_core; no dependencies.
`timescale 1ns / 1ps
package sbc_pkg;

    // Default sizes
    localparam int MEM_DEPTH_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int CODE_DEPTH_DEF  = 1024;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CADDR_W  = 10;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 3;
    localparam int PC_OUT_W = 11;
    localparam int SP_OUT_W = 7;

    // Commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Status codes
    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_OVF   = 3'd2;
    localparam logic [2:0] ST_UNF   = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_RANGE = 3'd5;
    localparam logic [2:0] ST_BADOP = 3'd6;
    localparam logic [2:0] ST_END   = 3'd7;

    // Opcodes
    localparam logic [7:0] OP_PUSH  = 8'h01;
    localparam logic [7:0] OP_POP   = 8'h02;
    localparam logic [7:0] OP_ADD   = 8'h03;
    localparam logic [7:0] OP_SUB   = 8'h04;
    localparam logic [7:0] OP_MUL   = 8'h05;
    localparam logic [7:0] OP_LOAD  = 8'h06;
    localparam logic [7:0] OP_STORE = 8'h07;
    localparam logic [7:0] OP_PRINT = 8'h08;
    localparam logic [7:0] OP_HALT  = 8'h09;
    localparam logic [7:0] OP_CALLB = 8'h0A;
    localparam logic [7:0] OP_DUP   = 8'h0B;
    localparam logic [7:0] OP_SWAP  = 8'h0C;
    localparam logic [7:0] OP_JMP   = 8'h0D;
    localparam logic [7:0] OP_JZ    = 8'h0E;
    localparam logic [7:0] OP_NEG   = 8'h0F;
    localparam logic [7:0] OP_MOD   = 8'h10;

    // Shared arithmetic unit operations
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_MOD = 2'd3;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

endpackage

FILE: sv/sbc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/sbc_alu.sv
// Shared 64-bit arithmetic unit: add/sub, 64-step shift-add
// multiply and restoring truncating remainder. Depends on sbc_pkg.
`timescale 1ns / 1ps
module sbc_alu (
    input  logic             aclk,
    input  logic             aresetn,
    input  sbc_pkg::alu_req_t req,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    output logic             done,
    output logic [63:0]      result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [1:0]  op_reg, op_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [64:0] trial;
    logic [64:0] diff;

    // Remainder step: shift in next dividend bit, subtract when it fits
    assign trial = {acc_reg, x_reg[63]};
    assign diff  = trial - {1'b0, y_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start) begin
            op_next  = req.op;
            neg_next = 1'b0;
            cnt_next = 7'd64;
            case (req.op)
                sbc_pkg::ALU_ADD: begin
                    acc_next  = a + b;
                    done_next = 1'b1;
                end
                sbc_pkg::ALU_SUB: begin
                    acc_next  = a - b;
                    done_next = 1'b1;
                end
                sbc_pkg::ALU_MUL: begin
                    acc_next  = '0;
                    x_next    = a;
                    y_next    = b;
                    busy_next = 1'b1;
                end
                default: begin
                    acc_next  = '0;
                    x_next    = a[63] ? (64'd0 - a) : a;
                    y_next    = b[63] ? (64'd0 - b) : b;
                    neg_next  = a[63];
                    busy_next = 1'b1;
                end
            endcase
        end else if (busy_reg) begin
            // Advance one bit of multiply or remainder
            if (op_reg == sbc_pkg::ALU_MUL) begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[62:0], 1'b0};
                y_next = {1'b0, y_reg[63:1]};
            end else begin
                acc_next = diff[64] ? trial[63:0] : diff[63:0];
                x_next   = {x_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    // Remainder takes the sign of the dividend
    assign done   = done_reg;
    assign result = neg_reg ? (64'd0 - acc_reg) : acc_reg;

endmodule

FILE: sv/stack_bytecode_core.sv
// Stack byte code core top level: sequencer, code/data/stack RAMs, output
// register. Depends on sbc_pkg, sbc_ram and sbc_alu.
`timescale 1ns / 1ps
// Each input transfer is one command: write a code byte, restart the program
// or execute one instruction; each produces exactly one result transfer with
// status, print and callback flags, program counter and stack depth. The
// block takes one command at a time. Instructions with an immediate read its
// bytes from code memory one at a time (push eight, load, store, jmp and jz
// four). Mul and mod run 64 iterations of the shared arithmetic unit. After
// reset a clearing pass over max(CODE_DEPTH, MEM_DEPTH) addresses zeroes the
// code and data memories; s_tready stays low during it.
module stack_bytecode_core #(
    parameter int MEM_DEPTH   = sbc_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = sbc_pkg::CODE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], code_addr[11:2], code_byte[19:12], zero fill
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], print_valid[3], print_value[67:4], callback_pulse[68],
    // program_counter[79:69], stack_depth[86:80], zero fill
    output logic [87:0] m_tdata
);

    localparam int CAW     = $clog2(CODE_DEPTH);
    localparam int MAW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SAW     = $clog2(STACK_DEPTH);
    localparam int PCW     = $clog2(CODE_DEPTH + 1);
    localparam int SPW     = $clog2(STACK_DEPTH + 1);
    localparam int CLR_LEN = (CODE_DEPTH > MEM_DEPTH) ? CODE_DEPTH : MEM_DEPTH;
    localparam int CLW     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
    localparam int SP_OUT_W = sbc_pkg::SP_OUT_W;
    localparam int PC_OUT_W = sbc_pkg::PC_OUT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_IMMW  = 4'd3;
    localparam logic [3:0] S_IMM   = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_LDW   = 4'd6;
    localparam logic [3:0] S_TOP   = 4'd7;
    localparam logic [3:0] S_SEC   = 4'd8;
    localparam logic [3:0] S_SWP   = 4'd9;
    localparam logic [3:0] S_AWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]     state_reg, state_next;
    logic [CLW-1:0] clr_reg, clr_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           run_reg, run_next;
    logic [2:0]     status_reg, status_next;
    logic [7:0]     op_reg, op_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [63:0]    imm_reg, imm_next;
    logic [63:0]    b_reg, b_next;
    logic           pv_reg, pv_next;
    logic [63:0]    pval_reg, pval_next;
    logic           cb_reg, cb_next;
    logic           mv_reg, mv_next;
    logic [87:0]    md_reg, md_next;

    logic [1:0]  in_cmd;
    logic [9:0]  in_addr;
    logic [7:0]  in_byte;
    logic        s_fire;
    logic [31:0] imm32;
    logic        mem_bad;
    logic        code_bad;
    logic [3:0]  imm_len;

    logic           code_we;
    logic [CAW-1:0] code_waddr;
    logic [7:0]     code_wdata;
    logic [7:0]     code_rdata;
    logic           data_we;
    logic [MAW-1:0] data_waddr;
    logic [63:0]    data_wdata;
    logic [63:0]    data_rdata;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [63:0]    stk_wdata;
    logic [SAW-1:0] stk_raddr;
    logic [63:0]    stk_rdata;

    sbc_pkg::alu_req_t alu_req;
    logic [63:0]       alu_a;
    logic [63:0]       alu_b;
    logic              alu_done;
    logic [63:0]       alu_result;

    assign in_cmd  = s_tdata[1:0];
    assign in_addr = s_tdata[11:2];
    assign in_byte = s_tdata[19:12];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Address immediate checks
    assign imm32    = imm_reg[63:32];
    assign mem_bad  = imm32[31] || (imm32 >= 32'(MEM_DEPTH));
    assign code_bad = imm32[31] || (imm32 >= 32'(CODE_DEPTH));

    // Memories
    sbc_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH), .AW(CAW)) u_code_ram (
        .aclk  (aclk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .raddr (pc_reg[CAW-1:0]),
        .rdata (code_rdata)
    );

    sbc_ram #(.WIDTH(64), .DEPTH(MEM_DEPTH), .AW(MAW)) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (imm_reg[32 +: MAW]),
        .rdata (data_rdata)
    );

    sbc_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Stack read: top of stack, or second entry while the top is captured
    assign stk_raddr = (state_reg == S_TOP) ? SAW'(sp_reg - SPW'(2))
                                            : SAW'(sp_reg - SPW'(1));

    // Immediate length per opcode
    always_comb begin
        case (code_rdata)
            sbc_pkg::OP_PUSH:  imm_len = 4'd8;
            sbc_pkg::OP_LOAD,
            sbc_pkg::OP_STORE,
            sbc_pkg::OP_JMP,
            sbc_pkg::OP_JZ:    imm_len = 4'd4;
            default:           imm_len = 4'd0;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        run_next    = run_reg;
        status_next = status_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        imm_next    = imm_reg;
        b_next      = b_reg;
        pv_next     = pv_reg;
        pval_next   = pval_reg;
        cb_next     = cb_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        code_we     = 1'b0;
        code_waddr  = clr_reg[CAW-1:0];
        code_wdata  = '0;
        data_we     = 1'b0;
        data_waddr  = clr_reg[MAW-1:0];
        data_wdata  = '0;
        stk_we      = 1'b0;
        stk_waddr   = SAW'(sp_reg - SPW'(1));
        stk_wdata   = stk_rdata;
        alu_req     = '0;
        alu_a       = '0;
        alu_b       = stk_rdata;

        // Drop the result once taken
        if (m_tvalid && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                // Zero code and data memories
                code_we = (32'(clr_reg) < 32'(CODE_DEPTH));
                data_we = (32'(clr_reg) < 32'(MEM_DEPTH));
                clr_next = clr_reg + CLW'(1);
                if (clr_reg == CLW'(CLR_LEN - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    pv_next    = 1'b0;
                    pval_next  = '0;
                    cb_next    = 1'b0;
                    state_next = S_DONE;
                    case (in_cmd)
                        sbc_pkg::CMD_WRITE: begin
                            code_we    = (32'(in_addr) < 32'(CODE_DEPTH));
                            code_waddr = CAW'(in_addr);
                            code_wdata = in_byte;
                        end
                        sbc_pkg::CMD_RESTART: begin
                            pc_next     = '0;
                            sp_next     = '0;
                            run_next    = 1'b1;
                            status_next = sbc_pkg::ST_RUN;
                        end
                        sbc_pkg::CMD_EXEC: begin
                            if (run_reg) begin
                                if (32'(pc_reg) >= 32'(CODE_DEPTH)) begin
                                    pc_next     = PCW'(CODE_DEPTH);
                                    run_next    = 1'b0;
                                    status_next = sbc_pkg::ST_END;
                                end else begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // Latch opcode, check immediate against end of code
                op_next  = code_rdata;
                pc_next  = pc_reg + PCW'(1);
                cnt_next = imm_len;
                if (imm_len == 4'd0) begin
                    state_next = S_EXEC;
                end else if (32'(pc_reg) + 32'd1 + 32'(imm_len) > 32'(CODE_DEPTH)) begin
                    pc_next     = PCW'(CODE_DEPTH);
                    run_next    = 1'b0;
                    status_next = sbc_pkg::ST_END;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_IMMW;
                end
            end
            S_IMMW: begin
                state_next = S_IMM;
            end
            S_IMM: begin
                // Shift in immediate byte, little-endian
                imm_next = {code_rdata, imm_reg[63:8]};
                pc_next  = pc_reg + PCW'(1);
                cnt_next = cnt_reg - 4'd1;
                state_next = (cnt_reg == 4'd1) ? S_EXEC : S_IMMW;
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (op_reg)
                    sbc_pkg::OP_PUSH: begin
                        if (32'(sp_reg) >= 32'(STACK_DEPTH)) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_OVF;
                        end else begin
                            stk_we    = 1'b1;
                            stk_waddr = SAW'(sp_reg);
                            stk_wdata = imm_reg;
                            sp_next   = sp_reg + SPW'(1);
                        end
                    end
                    sbc_pkg::OP_POP: begin
                        if (sp_reg == '0) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_UNF;
                        end else begin
                            sp_next = sp_reg - SPW'(1);
                        end
                    end
                    sbc_pkg::OP_ADD, sbc_pkg::OP_SUB, sbc_pkg::OP_MUL,
                    sbc_pkg::OP_MOD, sbc_pkg::OP_SWAP: begin
                        if (sp_reg < SPW'(2)) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_UNF;
                        end else begin
                            state_next = S_TOP;
                        end
                    end
                    sbc_pkg::OP_LOAD: begin
                        if (mem_bad) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_RANGE;
                        end else if (32'(sp_reg) >= 32'(STACK_DEPTH)) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_OVF;
                        end else begin
                            state_next = S_LDW;
                        end
                    end
                    sbc_pkg::OP_STORE: begin
                        if (mem_bad) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_RANGE;
                        end else if (sp_reg == '0) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_UNF;
                        end else begin
                            state_next = S_TOP;
                        end
                    end
                    sbc_pkg::OP_PRINT, sbc_pkg::OP_JZ, sbc_pkg::OP_NEG: begin
                        if (sp_reg == '0) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_UNF;
                        end else begin
                            state_next = S_TOP;
                        end
                    end
                    sbc_pkg::OP_DUP: begin
                        if (sp_reg == '0) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_UNF;
                        end else if (32'(sp_reg) >= 32'(STACK_DEPTH)) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_OVF;
                        end else begin
                            state_next = S_TOP;
                        end
                    end
                    sbc_pkg::OP_HALT: begin
                        run_next = 1'b0; status_next = sbc_pkg::ST_HALT;
                    end
                    sbc_pkg::OP_CALLB: begin
                        cb_next = 1'b1;
                    end
                    sbc_pkg::OP_JMP: begin
                        if (code_bad) begin
                            run_next = 1'b0; status_next = sbc_pkg::ST_RANGE;
                        end else begin
                            pc_next = PCW'(imm32);
                        end
                    end
                    default: begin
                        run_next = 1'b0; status_next = sbc_pkg::ST_BADOP;
                    end
                endcase
            end
            S_LDW: begin
                // Push loaded word
                stk_we     = 1'b1;
                stk_waddr  = SAW'(sp_reg);
                stk_wdata  = data_rdata;
                sp_next    = sp_reg + SPW'(1);
                state_next = S_DONE;
            end
            S_TOP: begin
                // Top of stack is on the read port
                b_next     = stk_rdata;
                state_next = S_DONE;
                case (op_reg)
                    sbc_pkg::OP_STORE: begin
                        data_we    = 1'b1;
                        data_waddr = imm_reg[32 +: MAW];
                        data_wdata = stk_rdata;
                        sp_next    = sp_reg - SPW'(1);
                    end
                    sbc_pkg::OP_PRINT: begin
                        pv_next   = 1'b1;
                        pval_next = stk_rdata;
                        sp_next   = sp_reg - SPW'(1);
                    end
                    sbc_pkg::OP_DUP: begin
                        stk_we    = 1'b1;
                        stk_waddr = SAW'(sp_reg);
                        sp_next   = sp_reg + SPW'(1);
                    end
                    sbc_pkg::OP_JZ: begin
                        sp_next = sp_reg - SPW'(1);
                        if (stk_rdata == 64'd0) begin
                            if (code_bad) begin
                                run_next = 1'b0; status_next = sbc_pkg::ST_RANGE;
                            end else begin
                                pc_next = PCW'(imm32);
                            end
                        end
                    end
                    sbc_pkg::OP_NEG: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = sbc_pkg::ALU_SUB;
                        state_next    = S_AWAIT;
                    end
                    default: begin
                        state_next = S_SEC;
                    end
                endcase
            end
            S_SEC: begin
                // Second entry is on the read port
                alu_a = stk_rdata;
                alu_b = b_reg;
                state_next = S_AWAIT;
                case (op_reg)
                    sbc_pkg::OP_SWAP: begin
                        stk_we     = 1'b1;
                        stk_wdata  = stk_rdata;
                        state_next = S_SWP;
                    end
                    sbc_pkg::OP_ADD: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = sbc_pkg::ALU_ADD;
                    end
                    sbc_pkg::OP_SUB: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = sbc_pkg::ALU_SUB;
                    end
                    sbc_pkg::OP_MUL: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = sbc_pkg::ALU_MUL;
                    end
                    default: begin
                        if (b_reg == 64'd0) begin
                            run_next    = 1'b0;
                            status_next = sbc_pkg::ST_DIV0;
                            state_next  = S_DONE;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = sbc_pkg::ALU_MOD;
                        end
                    end
                endcase
            end
            S_SWP: begin
                stk_we     = 1'b1;
                stk_waddr  = SAW'(sp_reg - SPW'(2));
                stk_wdata  = b_reg;
                state_next = S_DONE;
            end
            S_AWAIT: begin
                // Write back when the shared unit finishes
                if (alu_done) begin
                    stk_we     = 1'b1;
                    stk_wdata  = alu_result;
                    state_next = S_DONE;
                    if (op_reg != sbc_pkg::OP_NEG) begin
                        stk_waddr = SAW'(sp_reg - SPW'(2));
                        sp_next   = sp_reg - SPW'(1);
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {1'b0, SP_OUT_W'(sp_reg), PC_OUT_W'(pc_reg), cb_reg,
                                  pval_reg, pv_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= '0;
            sp_reg     <= '0;
            run_reg    <= 1'b0;
            status_reg <= sbc_pkg::ST_HALT;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
            run_reg    <= run_next;
            status_reg <= status_next;
            mv_reg     <= mv_next;
        end
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        imm_reg  <= imm_next;
        b_reg    <= b_next;
        pv_reg   <= pv_next;
        pval_reg <= pval_next;
        cb_reg   <= cb_next;
        md_reg   <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule
